// ===== hdl/sllm_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the linked list manager
`default_nettype none
package sllm_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int REQ_W      = 2;
  localparam int POS_W      = 10;
  localparam int DATA_W     = 8;
  localparam int STAT_W     = 2;
  localparam int LEN_W      = 10;
  localparam int CMP_W      = ((POS_W > IDX_W) ? POS_W : IDX_W) + 1;

  localparam logic [IDX_W-1:0] FREE_HEAD = '0;
  localparam logic [IDX_W-1:0] LIST_HEAD = IDX_W'(NODE_COUNT - 1);
  localparam logic [IDX_W-1:0] LAST_FREE = IDX_W'(NODE_COUNT - 2);

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {RA_FREE, RA_K, RA_Q} nx_rsel_t;
  typedef enum logic [1:0] {WA_CLR, WA_FREE, WA_K, WA_J} nx_wsel_t;
  typedef enum logic [1:0] {WD_CLR, WD_Q, WD_J} nx_dsel_t;

  typedef struct packed {
    logic              accept;
    nx_rsel_t          rsel;
    logic              nx_we;
    nx_wsel_t          wsel;
    nx_dsel_t          dsel;
    logic              dt_we;
    logic              clr_step;
    logic              walk_init;
    logic              walk_hop;
    logic              j_load;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              rd_load;
    logic              out_load;
    logic [STAT_W-1:0] status;
  } sllm_cmd_t;

  typedef struct packed {
    logic             clr_done;
    logic [REQ_W-1:0] req;
    logic             pos_ok;
    logic             steps_zero;
    logic             steps_one;
    logic             free_empty;
    logic             out_full;
  } sllm_stat_t;

endpackage
`default_nettype wire

// ===== hdl/sllm_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none
module sllm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/sllm_dp.sv =====
// datapath: node memories, walk registers, element counter and result register
`default_nettype none
module sllm_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire sllm_pkg::sllm_cmd_t        cmd,
  output sllm_pkg::sllm_stat_t            stat,
  input  wire logic [sllm_pkg::REQ_W-1:0]  in_req,
  input  wire logic [sllm_pkg::POS_W-1:0]  in_pos,
  input  wire logic [sllm_pkg::DATA_W-1:0] in_byte,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [sllm_pkg::STAT_W-1:0] out_status,
  output logic      [sllm_pkg::DATA_W-1:0] out_rdata,
  output logic      [sllm_pkg::LEN_W-1:0]  out_len
);
  import sllm_pkg::*;

  logic [REQ_W-1:0]  req;
  logic [POS_W-1:0]  pos;
  logic [DATA_W-1:0] byte_r;
  logic [IDX_W-1:0]  k;
  logic [IDX_W-1:0]  j;
  logic [POS_W-1:0]  steps;
  logic [IDX_W-1:0]  count;
  logic [IDX_W-1:0]  clr_idx;
  logic [DATA_W-1:0] rdata_r;

  logic [IDX_W-1:0]  nx_q;
  logic [IDX_W-1:0]  nx_raddr;
  logic [IDX_W-1:0]  nx_waddr;
  logic [IDX_W-1:0]  nx_wdata;
  logic [IDX_W-1:0]  clr_val;
  logic [DATA_W-1:0] dt_q;
  logic [CMP_W-1:0]  limit;

  // next-index memory
  sllm_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_next (
    .clk   (clk),
    .we    (cmd.nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (nx_raddr),
    .rdata (nx_q)
  );

  // node data memory
  sllm_ram #(.WIDTH(DATA_W), .DEPTH(NODE_COUNT)) u_data (
    .clk   (clk),
    .we    (cmd.dt_we),
    .waddr (nx_q),
    .wdata (byte_r),
    .raddr (k),
    .rdata (dt_q)
  );

  assign clr_val = (clr_idx < LAST_FREE) ? clr_idx + 1'b1 : FREE_HEAD;

  always_comb begin
    case (cmd.rsel)
      RA_FREE: nx_raddr = FREE_HEAD;
      RA_K:    nx_raddr = k;
      RA_Q:    nx_raddr = nx_q;
      default: nx_raddr = FREE_HEAD;
    endcase
    case (cmd.wsel)
      WA_CLR:  nx_waddr = clr_idx;
      WA_FREE: nx_waddr = FREE_HEAD;
      WA_K:    nx_waddr = k;
      WA_J:    nx_waddr = j;
      default: nx_waddr = FREE_HEAD;
    endcase
    case (cmd.dsel)
      WD_CLR:  nx_wdata = clr_val;
      WD_Q:    nx_wdata = nx_q;
      WD_J:    nx_wdata = j;
      default: nx_wdata = FREE_HEAD;
    endcase
  end

  assign limit = (req == REQ_INSERT) ? CMP_W'(count) + 1'b1 : CMP_W'(count);

  always_comb begin
    stat.clr_done   = (clr_idx == LIST_HEAD);
    stat.req        = req;
    stat.pos_ok     = (pos != '0) && (CMP_W'(pos) <= limit);
    stat.steps_zero = (steps == '0);
    stat.steps_one  = (steps == POS_W'(1));
    stat.free_empty = (nx_q == FREE_HEAD) || (nx_q >= LIST_HEAD);
    stat.out_full   = out_valid;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req     <= in_req;
      pos     <= in_pos;
      byte_r  <= in_byte;
      rdata_r <= '0;
    end
    if (cmd.walk_init) begin
      k     <= LIST_HEAD;
      steps <= (req == REQ_READ) ? pos : pos - 1'b1;
    end
    if (cmd.walk_hop) begin
      k     <= nx_q;
      steps <= steps - 1'b1;
    end
    if (cmd.j_load) begin
      j <= nx_q;
    end
    if (cmd.rd_load) begin
      rdata_r <= dt_q;
    end
    if (cmd.out_load) begin
      out_status <= cmd.status;
      out_rdata  <= rdata_r;
      out_len    <= LEN_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= count - 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_cnt_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.cnt_inc && cmd.cnt_dec))
    else $error("count raised and lowered together");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid)
    else $error("result register loaded while a result is pending");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    count <= LAST_FREE)
    else $error("element count beyond node capacity");

  a_take_node: assert property (@(posedge clk) disable iff (rst)
    cmd.dt_we |-> (nx_q != FREE_HEAD && nx_q != LIST_HEAD))
    else $error("data written into a head node");

endmodule
`default_nettype wire

// ===== hdl/sllm_ctrl.sv =====
// controller: memory clear pass and per-request sequencing of the datapath
`default_nettype none
module sllm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sllm_pkg::sllm_stat_t stat,
  output sllm_pkg::sllm_cmd_t       cmd
);
  import sllm_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_INS_A, S_INS_B, S_WALK_CHK, S_WALK, S_POST,
    S_RD_DATA, S_DEL_B, S_DEL_C, S_DEL_D, S_DEL_E, S_INS_D, S_INS_E, S_FIN
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STAT_W-1:0] status_code;
  logic [STAT_W-1:0] status_code_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next       = state;
    status_code_next = status_code;
    cmd              = '0;
    cmd.status       = status_code;
    case (state)
      S_CLEAR: begin
        cmd.nx_we    = 1'b1;
        cmd.wsel     = WA_CLR;
        cmd.dsel     = WD_CLR;
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept       = 1'b1;
          status_code_next = ST_OK;
          state_next       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.req == REQ_INSERT) begin
          if (stat.pos_ok) begin
            cmd.rsel   = RA_FREE;
            state_next = S_INS_A;
          end else begin
            status_code_next = ST_RANGE;
            state_next       = S_FIN;
          end
        end else if (stat.req == REQ_DELETE || stat.req == REQ_READ) begin
          if (stat.pos_ok) begin
            cmd.walk_init = 1'b1;
            state_next    = S_WALK_CHK;
          end else begin
            status_code_next = ST_RANGE;
            state_next       = S_FIN;
          end
        end else begin
          state_next = S_FIN;
        end
      end
      S_INS_A: begin
        if (stat.free_empty) begin
          status_code_next = ST_FULL;
          state_next       = S_FIN;
        end else begin
          cmd.j_load = 1'b1;
          cmd.dt_we  = 1'b1;
          cmd.rsel   = RA_Q;
          state_next = S_INS_B;
        end
      end
      S_INS_B: begin
        cmd.nx_we     = 1'b1;
        cmd.wsel      = WA_FREE;
        cmd.dsel      = WD_Q;
        cmd.walk_init = 1'b1;
        state_next    = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (stat.steps_zero) begin
          state_next = S_POST;
        end else begin
          cmd.rsel   = RA_K;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk_hop = 1'b1;
        if (stat.steps_one) begin
          state_next = S_POST;
        end else begin
          cmd.rsel = RA_Q;
        end
      end
      S_POST: begin
        cmd.rsel = RA_K;
        if (stat.req == REQ_READ) begin
          state_next = S_RD_DATA;
        end else if (stat.req == REQ_DELETE) begin
          state_next = S_DEL_B;
        end else begin
          state_next = S_INS_D;
        end
      end
      S_RD_DATA: begin
        cmd.rd_load = 1'b1;
        state_next  = S_FIN;
      end
      S_DEL_B: begin
        cmd.j_load = 1'b1;
        cmd.rsel   = RA_Q;
        state_next = S_DEL_C;
      end
      S_DEL_C: begin
        cmd.nx_we  = 1'b1;
        cmd.wsel   = WA_K;
        cmd.dsel   = WD_Q;
        cmd.rsel   = RA_FREE;
        state_next = S_DEL_D;
      end
      S_DEL_D: begin
        cmd.nx_we  = 1'b1;
        cmd.wsel   = WA_J;
        cmd.dsel   = WD_Q;
        state_next = S_DEL_E;
      end
      S_DEL_E: begin
        cmd.nx_we   = 1'b1;
        cmd.wsel    = WA_FREE;
        cmd.dsel    = WD_J;
        cmd.cnt_dec = 1'b1;
        state_next  = S_FIN;
      end
      S_INS_D: begin
        cmd.nx_we  = 1'b1;
        cmd.wsel   = WA_J;
        cmd.dsel   = WD_Q;
        state_next = S_INS_E;
      end
      S_INS_E: begin
        cmd.nx_we   = 1'b1;
        cmd.wsel    = WA_K;
        cmd.dsel    = WD_J;
        cmd.cnt_inc = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      status_code <= ST_OK;
    end else begin
      state       <= state_next;
      status_code <= status_code_next;
    end
  end

  a_clear_closed: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("request taken during clear pass");

  a_full_only_insert: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.status == ST_FULL) |-> (stat.req == REQ_INSERT))
    else $error("no-free-node status on a non-insert request");

  a_walk_needs_steps: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_hop |-> !stat.steps_zero)
    else $error("walk hop with no steps left");

endmodule
`default_nettype wire

// ===== hdl/static_linked_list_manager_top.sv =====
// top level of the static linked list manager with free list
//
//  channel  dir  tdata                              tuser
//  s_*      in   [9:0] position, [17:10] elem_data   [1:0] req_type
//  m_*      out  [7:0] read_data, [17:8] list_length [1:0] status
//
//  after reset a clear pass rebuilds the free chain; s_tready stays low
//  one request at a time; a rejected position or an insert into a full store skips
//  the walk and goes on to its result
//  the walk advances one node per cycle through the read port of the next-index memory
//  a finished result waits in the output register; the next request is taken meanwhile
//  while m_tready is low a result holds and the following request stops before its output
`default_nettype none
module static_linked_list_manager_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // position, elem_data, zero fill
  input  wire logic [1:0]  s_tuser,  // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,  // read_data, list_length, zero fill
  output logic      [1:0]  m_tuser   // status
);
  import sllm_pkg::*;

  sllm_cmd_t         cmd;
  sllm_stat_t        stat;
  logic [STAT_W-1:0] out_status;
  logic [DATA_W-1:0] out_rdata;
  logic [LEN_W-1:0]  out_len;

  sllm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sllm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_req     (s_tuser),
    .in_pos     (s_tdata[POS_W-1:0]),
    .in_byte    (s_tdata[POS_W+DATA_W-1:POS_W]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_rdata  (out_rdata),
    .out_len    (out_len)
  );

  assign m_tuser = out_status;
  assign m_tdata = {6'd0, out_len, out_rdata};

endmodule
`default_nettype wire
